>>> hdl/binary_box_blur_majority_core_macros.svh
// Assertion macros shared by the blur core RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BINARY_BOX_BLUR_MAJORITY_CORE_MACROS_SVH
`define BINARY_BOX_BLUR_MAJORITY_CORE_MACROS_SVH

// Same-cycle implication.
`define BBBM_AST_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbbm assertion failed");

// Next-cycle implication.
`define BBBM_AST_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbbm assertion failed");

`endif

>>> hdl/bbbm_pkg.sv
// Package for the binary box blur majority core: sizes, result type, helpers.
// No dependencies; imported by every module of the core.
package bbbm_pkg;

	localparam int BLUR_RADIUS = 2;
	localparam int MAX_LINE    = 128;
	localparam int DIAM        = 2 * BLUR_RADIUS + 1;
	localparam int HALF_AREA   = (DIAM * DIAM) / 2;

	localparam int CELL_W   = $clog2(MAX_LINE);
	localparam int LMOD_W   = (DIAM > 1) ? $clog2(DIAM) : 1;
	localparam int COL_W    = $clog2(DIAM + 1);
	localparam int WIN_W    = $clog2(DIAM * DIAM + 1);
	localparam int LS_DEPTH = DIAM * MAX_LINE;
	localparam int LS_AW    = $clog2(LS_DEPTH);

	localparam int SIZE_W  = 8;
	localparam int COORD_W = 12;
	localparam int CFG_W   = 12;
	localparam int CFG_IW  = 2;

	typedef enum logic [CFG_IW-1:0] {
		REG_LINE_LENGTH = 2'd0,
		REG_LINE_COUNT  = 2'd1,
		REG_ORIGIN_ROW  = 2'd2,
		REG_ORIGIN_COL  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] grid_row;
		logic [COORD_W-1:0] grid_col;
		logic               blurred_occupied;
		logic               last_of_patch;
	} bbbm_result_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (int'(v) > MAX_LINE) begin
			r = SIZE_W'(MAX_LINE);
		end
		return r;
	endfunction

endpackage

>>> hdl/bbbm_out_buf.sv
// Two-entry result queue (head register plus skid) in front of the output port.
// Depends on bbbm_pkg for the result type and on the core macro header.
`include "binary_box_blur_majority_core_macros.svh"

module bbbm_out_buf
	import bbbm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  bbbm_result_t push_data,
	output logic         full,
	output logic         out_valid,
	input  logic         out_stall,
	output bbbm_result_t out_data
);

	logic         head_v_q;
	logic         skid_v_q;
	bbbm_result_t head_q;
	bbbm_result_t skid_q;
	logic         pop;

	assign pop       = head_v_q && !out_stall;
	assign full      = head_v_q && skid_v_q;
	assign out_valid = head_v_q;
	assign out_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!head_v_q || pop) begin
			if (skid_v_q) begin
				head_v_q <= 1'b1;
				skid_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!head_v_q || pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	`BBBM_AST_IMP(a_skid_behind_head, !head_v_q, !skid_v_q)
	`BBBM_AST_IMP(a_no_push_when_full, push, !full)
	`BBBM_AST_NXT(a_drain_last, pop && !skid_v_q && !push, !head_v_q)

endmodule

>>> hdl/binary_box_blur_majority_core.sv
// Binary box blur with majority threshold: one cell per beat in, one result per window.
// Path: s1 register, then output queue head; one beat per cycle while in_stall is low.
// Rate is set by the single read-modify-write pass on the line and column-sum stores.
// Input stalls only while a result waits and the two-entry output queue is full.
// Reset clears counters and registers (length/count 128, origins 0); stores are not cleared.
// Depends on bbbm_pkg, bbbm_out_buf and the core macro header.
`include "binary_box_blur_majority_core_macros.svh"

module binary_box_blur_majority_core
	import bbbm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                occupied,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [COORD_W-1:0]  grid_row,
	output logic [COORD_W-1:0]  grid_col,
	output logic                blurred_occupied,
	output logic                last_of_patch
);

	logic [SIZE_W-1:0]  len_q, cnt_q;
	logic [COORD_W-1:0] org_row_q, org_col_q;
	logic [CELL_W-1:0]  cell_q, line_q;
	logic [LMOD_W-1:0]  lmod_q;
	logic [WIN_W-1:0]   win_q;
	logic [COL_W-1:0]   dly_q [DIAM];

	logic               ls_mem [LS_DEPTH];
	logic [COL_W-1:0]   cs_mem [MAX_LINE];

	logic               valid_s1;
	logic               bit_s1, res_s1, last_s1, fwd_s1, ls_rd_s1;
	logic [CELL_W-1:0]  c_s1, l_s1;
	logic [LS_AW-1:0]   ls_addr_s1;
	logic [COL_W-1:0]   cs_rd_s1, fwdv_s1;

	logic [SIZE_W-1:0]  len_eff, cnt_eff;
	logic               accept, line_end, patch_end, res_now;
	logic [LS_AW-1:0]   ls_addr;
	logic               s1_done, q_full;
	logic [COL_W-1:0]   col_base, col_sum, col;
	logic [WIN_W-1:0]   win_base, win_add, win_old, win;
	bbbm_result_t       res_data, out_data;

	cfg_reg_t cfg_sel;
	assign cfg_sel = cfg_reg_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= SIZE_W'(128);
			cnt_q     <= SIZE_W'(128);
			org_row_q <= '0;
			org_col_q <= '0;
		end else if (cfg_we) begin
			case (cfg_sel)
				REG_LINE_LENGTH: len_q     <= cfg_data[SIZE_W-1:0];
				REG_LINE_COUNT:  cnt_q     <= cfg_data[SIZE_W-1:0];
				REG_ORIGIN_ROW:  org_row_q <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_COL:  org_col_q <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// front: position counters and store addressing
	assign len_eff   = clamp_size(len_q);
	assign cnt_eff   = clamp_size(cnt_q);
	assign line_end  = (9'(cell_q) + 9'd1) >= 9'(len_eff);
	assign patch_end = line_end && ((9'(line_q) + 9'd1) >= 9'(cnt_eff));
	assign res_now   = (int'(line_q) >= 2 * BLUR_RADIUS) && (int'(cell_q) >= 2 * BLUR_RADIUS);
	assign ls_addr   = LS_AW'(int'(lmod_q) * MAX_LINE + int'(cell_q));

	assign in_stall = valid_s1 && res_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign s1_done  = valid_s1 && !(res_s1 && q_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q   <= '0;
			line_q   <= '0;
			lmod_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (patch_end) begin
					cell_q <= '0;
					line_q <= '0;
					lmod_q <= '0;
				end else if (line_end) begin
					cell_q <= '0;
					line_q <= line_q + CELL_W'(1);
					lmod_q <= (int'(lmod_q) == DIAM - 1) ? '0 : lmod_q + LMOD_W'(1);
				end else begin
					cell_q <= cell_q + CELL_W'(1);
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bit_s1     <= occupied;
			c_s1       <= cell_q;
			l_s1       <= line_q;
			res_s1     <= res_now;
			last_s1    <= patch_end;
			ls_addr_s1 <= ls_addr;
			fwd_s1     <= s1_done && (c_s1 == cell_q);
			fwdv_s1    <= col;
		end
	end

	// stores: read on accept, written when the item leaves s1
	always_ff @(posedge clk) begin
		if (accept) begin
			ls_rd_s1 <= ls_mem[ls_addr];
			cs_rd_s1 <= cs_mem[cell_q];
		end
		if (s1_done) begin
			ls_mem[ls_addr_s1] <= bit_s1;
			cs_mem[c_s1]       <= col;
		end
	end

	// s1: column and window sums
	assign col_base = (l_s1 == '0) ? '0 : (fwd_s1 ? fwdv_s1 : cs_rd_s1);
	assign col_sum  = col_base + COL_W'(bit_s1);
	assign col      = ((int'(l_s1) >= DIAM) && (col_sum >= COL_W'(ls_rd_s1))) ?
		col_sum - COL_W'(ls_rd_s1) : col_sum;

	assign win_base = (c_s1 == '0) ? '0 : win_q;
	assign win_add  = win_base + WIN_W'(col);
	assign win_old  = WIN_W'(dly_q[DIAM-1]);
	assign win      = (int'(c_s1) >= DIAM) ?
		((win_add >= win_old) ? win_add - win_old : '0) : win_add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_done) begin
			win_q <= last_s1 ? '0 : win;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			dly_q[0] <= col;
			for (int i = 1; i < DIAM; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	assign res_data.grid_row         = org_row_q + COORD_W'(c_s1) - COORD_W'(BLUR_RADIUS);
	assign res_data.grid_col         = org_col_q + COORD_W'(l_s1) - COORD_W'(BLUR_RADIUS);
	assign res_data.blurred_occupied = win > WIN_W'(HALF_AREA);
	assign res_data.last_of_patch    = last_s1;

	bbbm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_done && res_s1),
		.push_data (res_data),
		.full      (q_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign grid_row         = out_data.grid_row;
	assign grid_col         = out_data.grid_col;
	assign blurred_occupied = out_data.blurred_occupied;
	assign last_of_patch    = out_data.last_of_patch;

	`BBBM_AST_NXT(a_patch_wrap, accept && patch_end, cell_q == '0 && line_q == '0 && lmod_q == '0)
	`BBBM_AST_NXT(a_s1_hold, valid_s1 && !s1_done, valid_s1 && $stable(c_s1) && $stable(l_s1))
	`BBBM_AST_NXT(a_col_forward, accept && s1_done && (c_s1 == cell_q), fwd_s1)

endmodule
